// ===== src/lpe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants of the log packet encoder.
// ----------------------------------------------------------------------------
package lpe_pkg;

    // ring size default and register reset
    localparam int unsigned BUFFER_BYTES_DEF = 16384;
    localparam logic [15:0] MAX_LINE_RESET   = 16'd1024;

    // register indexes
    localparam logic REG_MAX_LINE = 1'b0;

    // item kinds
    localparam logic ACT_HEADER = 1'b0;
    localparam logic ACT_TEXT   = 1'b1;

    // record phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TEXT = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;

    // shared unit operations
    typedef logic t_alu_op;
    localparam t_alu_op ALU_SUB  = 1'b0;
    localparam t_alu_op ALU_SHR6 = 1'b1;

    typedef struct packed {
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    // byte codes
    localparam logic [7:0] BYTE_GROUP = 8'hc0;
    localparam logic [7:0] BYTE_FINAL = 8'h80;
    localparam logic [7:0] BYTE_NEG   = 8'h20;
    localparam logic [7:0] BYTE_FULL  = 8'hff;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

endpackage

`default_nettype wire

// ===== src/lpe_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpe_rec_if / lpe_wr_if
// Valid/ready channels: record items in, ring writes out.
// ----------------------------------------------------------------------------
interface lpe_rec_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [63:0] time_seconds;
    logic        [29:0] nanoseconds;
    logic        [4:0]  log_level;
    logic        [31:0] thread_id;
    logic        [15:0] text_length;
    logic        [7:0]  text_byte;

    modport source (output valid, action, time_seconds, nanoseconds, log_level,
                    thread_id, text_length, text_byte, input ready);
    modport sink   (input valid, action, time_seconds, nanoseconds, log_level,
                    thread_id, text_length, text_byte, output ready);
endinterface

interface lpe_wr_if;
    logic        valid;
    logic        ready;
    logic [13:0] write_address;
    logic [7:0]  write_byte;
    logic        last_of_run;
    logic        record_committed;
    logic        compaction_wanted;

    modport source (output valid, write_address, write_byte, last_of_run,
                    record_committed, compaction_wanted, input ready);
    modport sink   (input valid, write_address, write_byte, last_of_run,
                    record_committed, compaction_wanted, output ready);
endinterface

`default_nettype wire

// ===== src/log_packet_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// log_packet_encoder
// Frames log records into (ring address, byte) writes with a header,
// text, checksum and terminator.
// ----------------------------------------------------------------------------
//  port       dir  role
//  i_rec      in   record items: header (action 0) or one text byte
//  o_wr       out  ring writes, one byte per transfer
//  psel...    in   APB register port, max_line_length at address 0
//
//  A header runs S_REL and S_NEG in the shared subtract/shift unit, then S_CHK,
//  then emits one byte per cycle while the output slot is free (up to 11 seconds
//  groups, 5 nanosecond bytes, up to 6 thread groups). Closing emits checksum
//  and terminator; a NUL in text emits a NUL, then the header. i_rec.ready is
//  low while a sequence runs and while the output register holds an untaken
//  transfer. Reset is synchronous; the block is ready right after it.
// ----------------------------------------------------------------------------
module log_packet_encoder #(
    parameter int unsigned BUFFER_BYTES = lpe_pkg::BUFFER_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lpe_rec_if.sink     i_rec,
    lpe_wr_if.source    o_wr,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = $clog2(BUFFER_BYTES);
    localparam logic [AW-1:0] POS_LAST = AW'(BUFFER_BYTES - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_REL  = 4'd1;
    localparam logic [3:0] S_NEG  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_NUL  = 4'd4;
    localparam logic [3:0] S_SEC  = 4'd5;
    localparam logic [3:0] S_NANO = 4'd6;
    localparam logic [3:0] S_TID  = 4'd7;
    localparam logic [3:0] S_CK   = 4'd8;
    localparam logic [3:0] S_END  = 4'd9;

    logic [15:0] max_line;

    lpe_apb_regs u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_max_line_length (max_line)
    );

    // state
    logic [3:0]    r_state, n_state;
    logic [63:0]   r_total, n_total;
    logic [63:0]   r_pend, n_pend;
    logic [AW-1:0] r_tot_pos, n_tot_pos;
    logic [AW-1:0] r_pos, n_pos;
    logic [63:0]   r_base, n_base;
    logic [63:0]   r_ssec, n_ssec;
    logic [29:0]   r_snano, n_snano;
    logic [4:0]    r_slvl, n_slvl;
    logic [31:0]   r_stid, n_stid;
    logic [7:0]    r_sum, n_sum;
    logic [15:0]   r_rem, n_rem;
    logic [1:0]    r_phase, n_phase;
    logic [63:0]   r_acc, n_acc;
    logic          r_neg, n_neg;
    logic          r_cmp, n_cmp;
    logic          r_nul, n_nul;
    logic [2:0]    r_cnt, n_cnt;

    // output register
    logic          r_ov, n_ov;
    logic [13:0]   r_oaddr, n_oaddr;
    logic [7:0]    r_obyte, n_obyte;
    logic          r_olast, n_olast;
    logic          r_ocom, n_ocom;
    logic          r_ocmp, n_ocmp;

    lpe_pkg::t_alu_req alu_req;
    logic [63:0]       alu_y;

    lpe_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    logic        slot_free;
    logic        take;
    logic        e_en;
    logic [7:0]  e_byte;
    logic        e_last;
    logic        e_com;
    logic        e_cmp;
    logic [15:0] len_m1;
    logic [7:0]  ck;

    assign slot_free   = !r_ov || o_wr.ready;
    assign i_rec.ready = (r_state == S_IDLE) && slot_free;
    assign take        = i_rec.valid && i_rec.ready;
    assign len_m1      = i_rec.text_length - 16'd1;
    assign ck          = (~r_sum == 8'd0) ? lpe_pkg::BYTE_FULL : ~r_sum;

    // operand selection for the shared unit
    always_comb begin
        alu_req.op = lpe_pkg::ALU_SHR6;
        alu_req.a  = r_acc;
        alu_req.b  = 64'd0;
        case (r_state)
            S_REL: begin
                alu_req.op = lpe_pkg::ALU_SUB;
                alu_req.a  = r_ssec;
                alu_req.b  = r_base;
            end
            S_NEG: begin
                alu_req.op = lpe_pkg::ALU_SUB;
                alu_req.a  = 64'd0;
                alu_req.b  = r_acc;
            end
            default: begin
                alu_req.op = lpe_pkg::ALU_SHR6;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_pend    = r_pend;
        n_tot_pos = r_tot_pos;
        n_pos     = r_pos;
        n_base    = r_base;
        n_ssec    = r_ssec;
        n_snano   = r_snano;
        n_slvl    = r_slvl;
        n_stid    = r_stid;
        n_sum     = r_sum;
        n_rem     = r_rem;
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_cmp     = r_cmp;
        n_nul     = r_nul;
        n_cnt     = r_cnt;
        e_en      = 1'b0;
        e_byte    = 8'd0;
        e_last    = 1'b0;
        e_com     = 1'b0;
        e_cmp     = r_cmp;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_cmp = 1'b0;
                    e_cmp = 1'b0;
                    n_nul = 1'b0;
                    if (i_rec.action == lpe_pkg::ACT_HEADER) begin
                        // open a record at the committed end
                        n_pend    = r_total;
                        n_pos     = r_tot_pos;
                        n_phase   = lpe_pkg::PH_IDLE;
                        n_rem     = 16'd0;
                        if (i_rec.text_length == 16'd0) begin
                            n_phase = lpe_pkg::PH_IDLE;
                        end else if (len_m1 > max_line) begin
                            n_phase = lpe_pkg::PH_SKIP;
                            n_rem   = i_rec.text_length;
                        end else begin
                            n_ssec  = i_rec.time_seconds;
                            n_snano = i_rec.nanoseconds;
                            n_slvl  = i_rec.log_level;
                            n_stid  = i_rec.thread_id;
                            n_rem   = i_rec.text_length;
                            n_phase = lpe_pkg::PH_TEXT;
                            n_state = S_REL;
                        end
                    end else if (r_phase == lpe_pkg::PH_SKIP) begin
                        // swallow the rest of a dropped record
                        if (r_rem != 16'd0) begin
                            n_rem = r_rem - 16'd1;
                        end
                        if (r_rem <= 16'd1) begin
                            n_phase = lpe_pkg::PH_IDLE;
                        end
                    end else if (r_phase == lpe_pkg::PH_TEXT) begin
                        if (r_rem <= 16'd1) begin
                            n_rem   = 16'd0;
                            n_phase = lpe_pkg::PH_IDLE;
                            n_state = S_CK;
                        end else if (i_rec.text_byte == lpe_pkg::CHAR_LF) begin
                            n_rem   = r_rem - 16'd1;
                            n_phase = lpe_pkg::PH_SKIP;
                            n_state = S_CK;
                        end else if (i_rec.text_byte == lpe_pkg::CHAR_NUL) begin
                            n_rem   = r_rem - 16'd1;
                            n_nul   = 1'b1;
                            n_state = S_REL;
                        end else begin
                            // plain text byte
                            n_rem  = r_rem - 16'd1;
                            n_sum  = r_sum + i_rec.text_byte;
                            e_en   = 1'b1;
                            e_byte = i_rec.text_byte;
                            e_last = 1'b1;
                        end
                    end
                end
            end
            S_REL: begin
                n_acc   = alu_y;
                n_neg   = 1'b0;
                n_state = S_NEG;
            end
            S_NEG: begin
                if (r_acc[63]) begin
                    n_acc = alu_y;
                    n_neg = 1'b1;
                end
                n_state = S_CHK;
            end
            S_CHK: begin
                // rebase or flag when seconds are out of reach
                if (|r_acc[63:23]) begin
                    if (r_nul ? (&r_pend) : (r_pend == 64'd0)) begin
                        n_base = r_ssec;
                        n_acc  = 64'd0;
                        n_neg  = 1'b0;
                    end else begin
                        n_cmp = 1'b1;
                    end
                end
                n_state = r_nul ? S_NUL : S_SEC;
            end
            S_NUL: begin
                if (slot_free) begin
                    e_en    = 1'b1;
                    e_byte  = lpe_pkg::CHAR_NUL;
                    n_state = S_SEC;
                end
            end
            S_SEC: begin
                if (slot_free) begin
                    e_en = 1'b1;
                    if (|r_acc[63:5]) begin
                        e_byte = lpe_pkg::BYTE_GROUP | {2'b00, r_acc[5:0]};
                        n_acc  = alu_y;
                    end else begin
                        e_byte = lpe_pkg::BYTE_FINAL | (r_neg ? lpe_pkg::BYTE_NEG : 8'd0)
                                 | {3'b000, r_acc[4:0]};
                        n_cnt   = 3'd0;
                        n_state = S_NANO;
                    end
                end
            end
            S_NANO: begin
                if (slot_free) begin
                    e_en = 1'b1;
                    case (r_cnt)
                        3'd0:    e_byte = lpe_pkg::BYTE_FINAL | {1'b0, r_snano[6:0]};
                        3'd1:    e_byte = lpe_pkg::BYTE_FINAL | {1'b0, r_snano[13:7]};
                        3'd2:    e_byte = lpe_pkg::BYTE_FINAL | {1'b0, r_snano[20:14]};
                        3'd3:    e_byte = lpe_pkg::BYTE_FINAL | {1'b0, r_snano[27:21]};
                        default: e_byte = lpe_pkg::BYTE_FINAL
                                          | {1'b0, r_slvl, r_snano[29:28]};
                    endcase
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd4) begin
                        n_acc   = {32'd0, r_stid};
                        n_state = S_TID;
                    end
                end
            end
            S_TID: begin
                if (slot_free) begin
                    e_en = 1'b1;
                    if (|r_acc[31:6]) begin
                        e_byte = lpe_pkg::BYTE_GROUP | {2'b00, r_acc[5:0]};
                        n_acc  = alu_y;
                    end else begin
                        e_byte  = lpe_pkg::BYTE_FINAL | {2'b00, r_acc[5:0]};
                        e_last  = 1'b1;
                        n_sum   = 8'd0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_CK: begin
                if (slot_free) begin
                    e_en    = 1'b1;
                    e_byte  = ck;
                    n_state = S_END;
                end
            end
            S_END: begin
                if (slot_free) begin
                    e_en      = 1'b1;
                    e_byte    = lpe_pkg::CHAR_NUL;
                    e_last    = 1'b1;
                    e_com     = 1'b1;
                    n_total   = r_pend + 64'd1;
                    n_tot_pos = (r_pos == POS_LAST) ? '0 : r_pos + AW'(1);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // load the output register and advance the write position
        n_ov    = r_ov && !o_wr.ready;
        n_oaddr = r_oaddr;
        n_obyte = r_obyte;
        n_olast = r_olast;
        n_ocom  = r_ocom;
        n_ocmp  = r_ocmp;
        if (e_en) begin
            n_ov    = 1'b1;
            n_oaddr = 14'(r_pos);
            n_obyte = e_byte;
            n_olast = e_last;
            n_ocom  = e_com;
            n_ocmp  = e_cmp;
            n_pend  = r_pend + 64'd1;
            n_pos   = (r_pos == POS_LAST) ? '0 : r_pos + AW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= 64'd0;
            r_pend    <= 64'd0;
            r_tot_pos <= '0;
            r_pos     <= '0;
            r_base    <= 64'd0;
            r_ssec    <= 64'd0;
            r_snano   <= 30'd0;
            r_slvl    <= 5'd0;
            r_stid    <= 32'd0;
            r_sum     <= 8'd0;
            r_rem     <= 16'd0;
            r_phase   <= lpe_pkg::PH_IDLE;
            r_cmp     <= 1'b0;
            r_nul     <= 1'b0;
            r_cnt     <= 3'd0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_pend    <= n_pend;
            r_tot_pos <= n_tot_pos;
            r_pos     <= n_pos;
            r_base    <= n_base;
            r_ssec    <= n_ssec;
            r_snano   <= n_snano;
            r_slvl    <= n_slvl;
            r_stid    <= n_stid;
            r_sum     <= n_sum;
            r_rem     <= n_rem;
            r_phase   <= n_phase;
            r_cmp     <= n_cmp;
            r_nul     <= n_nul;
            r_cnt     <= n_cnt;
            r_ov      <= n_ov;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_oaddr <= n_oaddr;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_ocom  <= n_ocom;
        r_ocmp  <= n_ocmp;
    end

    assign o_wr.valid             = r_ov;
    assign o_wr.write_address     = r_oaddr;
    assign o_wr.write_byte        = r_obyte;
    assign o_wr.last_of_run       = r_olast;
    assign o_wr.record_committed  = r_ocom;
    assign o_wr.compaction_wanted = r_ocmp;

endmodule

`default_nettype wire

// ===== src/lpe_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpe_alu
// Shared 64-bit subtract / shift-by-six unit of the header sequencer.
// ----------------------------------------------------------------------------
module lpe_alu (
    input  wire lpe_pkg::t_alu_req i_req,
    output logic [63:0]            o_y
);

    // one subtractor and one fixed shift, selected by the operation
    always_comb begin
        case (i_req.op)
            lpe_pkg::ALU_SUB:  o_y = i_req.a - i_req.b;
            lpe_pkg::ALU_SHR6: o_y = i_req.a >> 6;
            default:           o_y = i_req.a;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/lpe_apb_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpe_apb_regs
// APB register file: the maximum line length register.
// ----------------------------------------------------------------------------
module lpe_apb_regs (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_max_line_length
);

    logic [15:0] r_max_line;
    logic [15:0] n_max_line;
    logic        hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == lpe_pkg::REG_MAX_LINE);

    // take a write in the access phase
    always_comb begin
        n_max_line = r_max_line;
        if (psel && penable && pwrite && hit) begin
            n_max_line = pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line <= lpe_pkg::MAX_LINE_RESET;
        end else begin
            r_max_line <= n_max_line;
        end
    end

    // read back
    assign prdata            = hit ? {16'd0, r_max_line} : 32'd0;
    assign o_max_line_length = r_max_line;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the log packet encoder. Record items (headers and
// text bytes) go in over a valid/ready channel with random gaps. A predictor
// works out the ring writes that each accepted item causes. Every write that
// leaves the block is compared field by field with the oldest predicted one.
// The line limit is changed between phases through the APB port while the
// block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam logic [2:0]  MAX_LINE_ADDR = {lpe_pkg::REG_MAX_LINE, 2'b00};

    typedef struct {
        logic               action;
        logic signed [63:0] secs;
        logic        [29:0] nanos;
        logic        [4:0]  level;
        logic        [31:0] thread;
        logic        [15:0] len;
        logic        [7:0]  ch;
    } t_record_item;

    typedef struct {
        logic [13:0] addr;
        logic [7:0]  data;
        logic        last;
        logic        committed;
        logic        compact;
    } t_ring_write;

    // Predicts ring writes per accepted item and checks the block's writes
    class ring_write_predictor;
        logic [15:0] max_line;
        logic [63:0] total_written;
        logic [63:0] next_pos;
        logic [63:0] secs_base;
        logic [63:0] hdr_secs;
        logic [29:0] hdr_nanos;
        logic [4:0]  hdr_level;
        logic [31:0] hdr_thread;
        logic [7:0]  text_sum;
        logic [15:0] left;
        logic [1:0]  rec_phase;
        logic        compact_flag;
        t_ring_write expected_writes[$];
        int unsigned mismatches;

        function new();
            max_line      = lpe_pkg::MAX_LINE_RESET;
            total_written = '0;
            next_pos      = '0;
            secs_base     = '0;
            hdr_secs      = '0;
            hdr_nanos     = '0;
            hdr_level     = '0;
            hdr_thread    = '0;
            text_sum      = '0;
            left          = '0;
            rec_phase     = lpe_pkg::PH_IDLE;
            mismatches    = 0;
        endfunction

        function int unsigned pending_writes();
            return expected_writes.size();
        endfunction

        function void emit_write(input logic [7:0] data, input logic committed);
            t_ring_write w;
            w.addr      = 14'(next_pos % lpe_pkg::BUFFER_BYTES_DEF);
            w.data      = data;
            w.last      = 1'b0;
            w.committed = committed;
            w.compact   = 1'b0;
            expected_writes.push_back(w);
            next_pos++;
        endfunction

        function logic [63:0] offset_from_base(input logic [63:0] secs, output logic neg);
            logic [63:0] rel;
            rel = secs - secs_base;
            neg = rel[63];
            if (neg) begin
                rel = -rel;
            end
            return rel;
        endfunction

        function void emit_header();
            logic [63:0] mag;
            logic        neg;
            logic [31:0] tid;
            mag = offset_from_base(hdr_secs, neg);
            tid = hdr_thread;
            // rebase only while nothing has been written yet
            if (mag > 64'h7fffff) begin
                if (next_pos == 0) begin
                    secs_base = hdr_secs;
                    mag = offset_from_base(hdr_secs, neg);
                end else begin
                    compact_flag = 1'b1;
                end
            end
            while (mag > 64'h1f) begin
                emit_write(lpe_pkg::BYTE_GROUP | {2'b00, mag[5:0]}, 1'b0);
                mag = mag >> 6;
            end
            emit_write(lpe_pkg::BYTE_FINAL | (neg ? lpe_pkg::BYTE_NEG : 8'h00)
                       | {3'b000, mag[4:0]}, 1'b0);
            emit_write(lpe_pkg::BYTE_FINAL | {1'b0, hdr_nanos[6:0]}, 1'b0);
            emit_write(lpe_pkg::BYTE_FINAL | {1'b0, hdr_nanos[13:7]}, 1'b0);
            emit_write(lpe_pkg::BYTE_FINAL | {1'b0, hdr_nanos[20:14]}, 1'b0);
            emit_write(lpe_pkg::BYTE_FINAL | {1'b0, hdr_nanos[27:21]}, 1'b0);
            emit_write(lpe_pkg::BYTE_FINAL | {1'b0, hdr_level, hdr_nanos[29:28]}, 1'b0);
            while (tid > 32'h3f) begin
                emit_write(lpe_pkg::BYTE_GROUP | {2'b00, tid[5:0]}, 1'b0);
                tid = tid >> 6;
            end
            emit_write(lpe_pkg::BYTE_FINAL | {2'b00, tid[5:0]}, 1'b0);
            text_sum = '0;
        endfunction

        function void close_record();
            logic [7:0] sum_byte;
            sum_byte = lpe_pkg::BYTE_FULL - text_sum;
            if (sum_byte == 8'h00) begin
                sum_byte = lpe_pkg::BYTE_FULL;
            end
            emit_write(sum_byte, 1'b0);
            emit_write(lpe_pkg::CHAR_NUL, 1'b1);
            total_written = next_pos;
        endfunction

        function void note_record_item(input t_record_item it);
            int unsigned first;
            logic [15:0] was;
            first = expected_writes.size();
            compact_flag = 1'b0;
            if (it.action == lpe_pkg::ACT_HEADER) begin
                // a header always restarts at the committed end
                next_pos  = total_written;
                rec_phase = lpe_pkg::PH_IDLE;
                left      = '0;
                if (it.len != 0) begin
                    if ((it.len - 16'd1) > max_line) begin
                        rec_phase = lpe_pkg::PH_SKIP;
                        left      = it.len;
                    end else begin
                        hdr_secs   = it.secs;
                        hdr_nanos  = it.nanos;
                        hdr_level  = it.level;
                        hdr_thread = it.thread;
                        left       = it.len;
                        rec_phase  = lpe_pkg::PH_TEXT;
                        emit_header();
                    end
                end
            end else if (rec_phase == lpe_pkg::PH_SKIP) begin
                if (left > 0) begin
                    left--;
                end
                if (left == 0) begin
                    rec_phase = lpe_pkg::PH_IDLE;
                end
            end else if (rec_phase == lpe_pkg::PH_TEXT) begin
                was  = left;
                left = (was > 0) ? was - 16'd1 : 16'd0;
                if (was <= 1) begin
                    close_record();
                    rec_phase = lpe_pkg::PH_IDLE;
                    left      = '0;
                end else if (it.ch == lpe_pkg::CHAR_LF) begin
                    close_record();
                    rec_phase = (left > 0) ? lpe_pkg::PH_SKIP : lpe_pkg::PH_IDLE;
                end else begin
                    emit_write(it.ch, 1'b0);
                    if (it.ch == lpe_pkg::CHAR_NUL) begin
                        emit_header();
                    end else begin
                        text_sum = text_sum + it.ch;
                    end
                end
            end
            // mark the run of writes this item caused
            for (int unsigned i = first; i < expected_writes.size(); i++) begin
                expected_writes[i].compact = compact_flag;
            end
            if (expected_writes.size() > first) begin
                expected_writes[expected_writes.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_ring_write(input t_ring_write got);
            t_ring_write want;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected write: addr %0d byte %02h last %0b cm %0b cp %0b",
                             got.addr, got.data, got.last, got.committed, got.compact);
                end
                return;
            end
            want = expected_writes.pop_front();
            if (got.addr != want.addr || got.data != want.data || got.last != want.last ||
                got.committed != want.committed || got.compact != want.compact) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch: expected addr %0d byte %02h last %0b cm %0b cp %0b",
                             want.addr, want.data, want.last, want.committed, want.compact);
                    $display("          got      addr %0d byte %02h last %0b cm %0b cp %0b",
                             got.addr, got.data, got.last, got.committed, got.compact);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lpe_rec_if rec_if ();
    lpe_wr_if  wr_if ();

    ring_write_predictor ring_pred = new();

    int unsigned items_sent   = 0;
    int unsigned xfer_count   = 0;
    int unsigned cycle_count  = 0;
    bit          sender_calm  = 1'b0;
    bit          receiver_calm = 1'b0;

    log_packet_encoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_if),
        .o_wr    (wr_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("log_packet_encoder test failed");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input t_record_item it);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) begin
            sender_calm = !sender_calm;
        end
        gap = sender_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            rec_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rec_if.valid        <= 1'b1;
        rec_if.action       <= it.action;
        rec_if.time_seconds <= it.secs;
        rec_if.nanoseconds  <= it.nanos;
        rec_if.log_level    <= it.level;
        rec_if.thread_id    <= it.thread;
        rec_if.text_length  <= it.len;
        rec_if.text_byte    <= it.ch;
        @(posedge i_clk);
        while (!rec_if.ready) @(posedge i_clk);
        ring_pred.note_record_item(it);
        items_sent++;
    endtask

    task automatic send_header(input logic [63:0] secs, input logic [29:0] nanos,
                               input logic [4:0] level, input logic [31:0] thread,
                               input logic [15:0] len);
        t_record_item it;
        it.action = lpe_pkg::ACT_HEADER;
        it.secs   = secs;
        it.nanos  = nanos;
        it.level  = level;
        it.thread = thread;
        it.len    = len;
        it.ch     = 8'($urandom);
        send_item(it);
    endtask

    // Header fields of a text item are noise; the block must ignore them
    task automatic send_text(input logic [7:0] ch);
        t_record_item it;
        it.action = lpe_pkg::ACT_TEXT;
        it.secs   = {$urandom, $urandom};
        it.nanos  = 30'($urandom);
        it.level  = 5'($urandom);
        it.thread = $urandom;
        it.len    = 16'($urandom);
        it.ch     = ch;
        send_item(it);
    endtask

    // Drop valid and wait until every predicted write has been taken
    task automatic wait_idle();
        rec_if.valid <= 1'b0;
        while (ring_pred.pending_writes() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_line(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LINE_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        ring_pred.max_line = value;
    endtask

    // One record with random fields, sometimes cut short or overrun
    task automatic random_record();
        logic [63:0] secs;
        logic [31:0] thread;
        logic [15:0] len;
        logic [7:0]  ch;
        int unsigned n_text;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    secs = {$urandom, $urandom};
            2:       secs = ($urandom_range(0, 1) == 0) ? 64'h8000_0000_0000_0000
                                                        : 64'h7fff_ffff_ffff_ffff;
            3:       secs = ring_pred.secs_base + 64'h7fffff;
            4:       secs = ring_pred.secs_base - 64'h800000;
            default: secs = ring_pred.secs_base + 64'($urandom_range(0, 4000)) - 64'd2000;
        endcase
        thread = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 63)) : $urandom;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            len = 16'd0;
        end else if (pick == 1) begin
            len = 16'($urandom);
        end else if (pick == 2) begin
            len = ring_pred.max_line + 16'd1;
        end else if (pick == 3) begin
            len = ring_pred.max_line + 16'd2;
        end else begin
            len = 16'($urandom_range(1, 12));
        end
        send_header(secs, 30'($urandom), 5'($urandom_range(0, 31)), thread, len);
        n_text = (len > 16) ? $urandom_range(0, 4) : 32'(len);
        pick = $urandom_range(0, 9);
        if (pick == 0 && n_text > 0) begin
            n_text = $urandom_range(0, n_text - 1);
        end else if (pick == 1) begin
            n_text = n_text + $urandom_range(1, 2);
        end
        repeat (n_text) begin
            pick = $urandom_range(0, 15);
            ch = (pick == 0) ? lpe_pkg::CHAR_LF :
                 (pick == 1) ? lpe_pkg::CHAR_NUL : 8'($urandom_range(0, 255));
            send_text(ch);
        end
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned stop;
        stop = items_sent + n_items;
        while (items_sent < stop) random_record();
        wait_idle();
    endtask

    // Ring write side: random stalls, two long holds to back up the block
    initial begin
        t_ring_write got;
        int unsigned stall;
        wr_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                receiver_calm = !receiver_calm;
            end
            stall = receiver_calm ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                wr_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            wr_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!wr_if.valid) @(posedge i_clk);
            got.addr      = wr_if.write_address;
            got.data      = wr_if.write_byte;
            got.last      = wr_if.last_of_run;
            got.committed = wr_if.record_committed;
            got.compact   = wr_if.compaction_wanted;
            ring_pred.check_ring_write(got);
            xfer_count++;
            if (xfer_count == 200 || xfer_count == 450) begin
                wr_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
        end
    end

    // Reset, directed records, then random phases at several line limits
    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        rec_if.valid        <= 1'b0;
        rec_if.action       <= lpe_pkg::ACT_HEADER;
        rec_if.time_seconds <= '0;
        rec_if.nanoseconds  <= '0;
        rec_if.log_level    <= '0;
        rec_if.thread_id    <= '0;
        rec_if.text_length  <= '0;
        rec_if.text_byte    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // text while idle, then an empty record
        send_text(8'h78);
        send_header(64'h0, 30'h0, 5'd0, 32'h0, 16'd0);
        // first record rebases seconds; all-ones fields
        send_header(64'h7fff_ffff_ffff_ffff, 30'h3fff_ffff, 5'd31, 32'hffff_ffff, 16'd3);
        send_text(8'hff);
        send_text(8'h01);
        send_text(8'h0a);
        // small negative offset, single-item record
        send_header(ring_pred.secs_base - 64'd5, 30'h0, 5'd0, 32'h0, 16'd1);
        send_text(8'h41);
        // far out of reach: compaction flagged, NUL repeats the header
        send_header(64'h0, 30'h1555_5555, 5'd10, 32'h0000_1000, 16'd4);
        send_text(8'h61);
        send_text(lpe_pkg::CHAR_NUL);
        send_text(8'h62);
        send_text(8'h0a);
        // edge of reach; checksum wraps to zero
        send_header(ring_pred.secs_base + 64'h7fffff, 30'h2aaa_aaaa, 5'd21, 32'h40, 16'd2);
        send_text(8'hff);
        send_text(8'h55);
        // just past reach; newline early, rest swallowed, then abandoned
        send_header(ring_pred.secs_base + 64'h800000, 30'h3f, 5'd1, 32'h3f, 16'd5);
        send_text(8'h68);
        send_text(lpe_pkg::CHAR_LF);
        send_text(8'h7a);
        // too long, then the longest accepted, abandoned by the next header
        send_header(ring_pred.secs_base, 30'h0, 5'd2, 32'h1, 16'd1026);
        send_text(8'h20);
        send_header(ring_pred.secs_base + 64'd1, 30'h1, 5'd3, 32'h2, 16'd1025);
        send_text(8'h31);
        send_header(ring_pred.secs_base + 64'd2, 30'h2, 5'd4, 32'h3, 16'd2);
        send_text(8'h32);
        send_text(8'h0a);
        wait_idle();

        // zero limit: only one-item records pass
        write_max_line(16'd0);
        send_header(ring_pred.secs_base + 64'd9, 30'h7, 5'd5, 32'h5, 16'd1);
        send_text(8'h0a);
        send_header(ring_pred.secs_base + 64'd9, 30'h7, 5'd5, 32'h5, 16'd2);
        send_text(8'h41);
        send_text(8'h42);
        send_text(8'h43);
        random_phase(25);

        // widest limit
        write_max_line(16'hffff);
        send_header(ring_pred.secs_base + 64'd100, 30'h0abc_def0, 5'd7, 32'h1234_5678, 16'hffff);
        send_text(8'h48);
        send_text(8'h49);
        send_text(lpe_pkg::CHAR_NUL);
        random_phase(50);

        write_max_line(16'd40);
        random_phase(50);

        write_max_line(lpe_pkg::MAX_LINE_RESET);
        random_phase(55);

        if (ring_pred.mismatches == 0 && ring_pred.pending_writes() == 0) begin
            $display("log_packet_encoder test passed");
        end else begin
            $display("log_packet_encoder test failed");
        end
        $finish;
    end

endmodule
